// ===== hdl/crg_pkg.sv =====
// ---------------------------------------------------------------------------
// crg_pkg
// Shared types and constants for the camera ray generator pipeline.
// ---------------------------------------------------------------------------
package crg_pkg;

  localparam int PIXEL_INDEX_BITS = 12;
  localparam int PIX_FIELD_BITS   = 12;
  localparam logic [PIX_FIELD_BITS-1:0] IDX_MASK =
    PIX_FIELD_BITS'((64'd1 << PIXEL_INDEX_BITS) - 64'd1);

  localparam int SQRT_STAGES = 31;
  localparam int QUOT_BITS   = 15;

  typedef enum logic [3:0] {
    REG_INV_ROW_X   = 4'd0,
    REG_INV_ROW_Y   = 4'd1,
    REG_INV_ROW_Z   = 4'd2,
    REG_TRANS_XY    = 4'd3,
    REG_TRANS_Z     = 4'd4,
    REG_PIXEL_PITCH = 4'd5,
    REG_HALF_W      = 4'd6,
    REG_HALF_H      = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][59:0] row;
    logic [63:0]      trans_xy;
    logic [31:0]      trans_z;
    logic [31:0]      pitch;
    logic [31:0]      half_w;
    logic [31:0]      half_h;
  } cfg_t;

  typedef struct packed {
    logic [PIX_FIELD_BITS-1:0] pixel_column;
    logic [PIX_FIELD_BITS-1:0] pixel_row;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] direction_x;
    logic signed [15:0] direction_y;
    logic signed [15:0] direction_z;
    logic               degenerate;
  } out_req_t;

  // magnitudes after normalizing shift, with their signs
  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic             deg;
  } vec_pass_t;

endpackage

// ===== hdl/crg_view.sv =====
// ---------------------------------------------------------------------------
// crg_view
// View plane point: half extent minus (2*index+1)*pitch, rounded to Q16.16.
// ---------------------------------------------------------------------------
module crg_view import crg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               valid_in,
  input  in_req_t            req,
  input  cfg_t               cfg,
  output logic               valid_out,
  output logic signed [31:0] wx,
  output logic signed [31:0] wy
);

  logic [PIX_FIELD_BITS-1:0] col_m, row_m;
  logic [PIX_FIELD_BITS:0]   odd_x, odd_y;
  logic [44:0]               prod_x, prod_y;
  logic                      v1;
  logic signed [45:0]        vx, vy, rx, ry;

  assign col_m = req.pixel_column & IDX_MASK;
  assign row_m = req.pixel_row & IDX_MASK;
  assign odd_x = {col_m, 1'b1};
  assign odd_y = {row_m, 1'b1};

  // exact in Q.31; arithmetic shift gives floor, so +2^14 rounds half up
  assign vx = $signed({7'b0, cfg.half_w, 7'b0}) - $signed({1'b0, prod_x});
  assign vy = $signed({7'b0, cfg.half_h, 7'b0}) - $signed({1'b0, prod_y});
  assign rx = (vx + 46'sd16384) >>> 15;
  assign ry = (vy + 46'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else if (adv) begin
      v1        <= valid_in;
      valid_out <= v1;
    end
    if (adv) begin
      prod_x <= 45'(odd_x) * 45'(cfg.pitch);
      prod_y <= 45'(odd_y) * 45'(cfg.pitch);
      wx     <= 32'(rx);
      wy     <= 32'(ry);
    end
  end

endmodule

// ===== hdl/crg_xform.sv =====
// ---------------------------------------------------------------------------
// crg_xform
// Inverse linear part applied to (wx, wy, -1): products, then row sums.
// ---------------------------------------------------------------------------
module crg_xform import crg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               valid_in,
  input  logic signed [31:0] wx,
  input  logic signed [31:0] wy,
  input  cfg_t               cfg,
  output logic               valid_out,
  output logic signed [53:0] d [3]
);

  logic signed [51:0] p [3][2];
  logic signed [19:0] mz [3];
  logic               v1;

  always_comb begin
    for (int r = 0; r < 3; r++) mz[r] = $signed(cfg.row[r][59:40]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else if (adv) begin
      v1        <= valid_in;
      valid_out <= v1;
    end
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p[r][0] <= 52'($signed(cfg.row[r][19:0])) * 52'(wx);
        p[r][1] <= 52'($signed(cfg.row[r][39:20])) * 52'(wy);
        // z term: entry times -1.0
        d[r] <= 54'(p[r][0]) + 54'(p[r][1]) - (54'(mz[r]) <<< 16);
      end
    end
  end

endmodule

// ===== hdl/crg_norm.sv =====
// ---------------------------------------------------------------------------
// crg_norm
// Magnitudes, shift below 2^30, squares and their sum.
// ---------------------------------------------------------------------------
module crg_norm import crg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               valid_in,
  input  logic signed [53:0] d [3],
  output logic               valid_out,
  output logic [61:0]        sumsq,
  output vec_pass_t          vec
);

  logic [53:0] mag5 [3], mag6 [3];
  logic [2:0]  neg5, neg6, neg7, neg8;
  logic [53:0] orr;
  logic [4:0]  s_cnt, s6;
  logic        deg6, deg7, deg8;
  logic [29:0] mag7 [3], mag8 [3];
  logic [59:0] sq8 [3];
  logic [3:0]  vp;

  // OR of magnitudes has the same bit length as the largest one
  always_comb begin
    orr   = mag5[0] | mag5[1] | mag5[2];
    s_cnt = '0;
    for (int i = 0; i < 24; i++) begin
      if (orr[30+i]) s_cnt = 5'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= '0;
      valid_out <= 1'b0;
    end else if (adv) begin
      vp        <= {vp[2:0], valid_in};
      valid_out <= vp[3];
    end
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        mag5[r] <= d[r][53] ? 54'(-d[r]) : 54'(d[r]);
        neg5[r] <= d[r][53];
        mag6[r] <= mag5[r];
        mag7[r] <= 30'(mag6[r] >> s6);
        mag8[r] <= mag7[r];
        sq8[r]  <= 60'(mag7[r]) * 60'(mag7[r]);
      end
      s6      <= s_cnt;
      deg6    <= (orr == '0);
      neg6    <= neg5;
      neg7    <= neg6;
      deg7    <= deg6;
      neg8    <= neg7;
      deg8    <= deg7;
      sumsq   <= 62'(sq8[0]) + 62'(sq8[1]) + 62'(sq8[2]);
      vec.mag <= {mag8[2], mag8[1], mag8[0]};
      vec.neg <= neg8;
      vec.deg <= deg8;
    end
  end

endmodule

// ===== hdl/crg_isqrt.sv =====
// ---------------------------------------------------------------------------
// crg_isqrt
// Floor square root, one result bit per pipeline stage.
// ---------------------------------------------------------------------------
module crg_isqrt import crg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        valid_in,
  input  logic [61:0] n_in,
  input  vec_pass_t   vec_in,
  output logic        valid_out,
  output logic [30:0] root,
  output vec_pass_t   vec_out
);

  logic [61:0] n_q    [SQRT_STAGES];
  logic [32:0] rem_q  [SQRT_STAGES];
  logic [30:0] root_q [SQRT_STAGES];
  vec_pass_t   vec_q  [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vld;

  logic [32:0] rem_n  [SQRT_STAGES];
  logic [30:0] root_n [SQRT_STAGES];
  logic [61:0] n_cur  [SQRT_STAGES];
  logic [32:0] rem_c  [SQRT_STAGES];
  logic [30:0] root_c [SQRT_STAGES];
  logic [34:0] rs     [SQRT_STAGES];
  logic [34:0] trial  [SQRT_STAGES];

  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      n_cur[k]  = (k == 0) ? n_in : n_q[k-1];
      rem_c[k]  = (k == 0) ? '0 : rem_q[k-1];
      root_c[k] = (k == 0) ? '0 : root_q[k-1];
      rs[k]     = {rem_c[k], n_cur[k][2*(SQRT_STAGES-1-k) +: 2]};
      trial[k]  = 35'({root_c[k], 2'b01});
      if (rs[k] >= trial[k]) begin
        rem_n[k]  = 33'(rs[k] - trial[k]);
        root_n[k] = {root_c[k][29:0], 1'b1};
      end else begin
        rem_n[k]  = 33'(rs[k]);
        root_n[k] = {root_c[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[SQRT_STAGES-2:0], valid_in};
    end
    if (adv) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        n_q[k]    <= n_cur[k];
        rem_q[k]  <= rem_n[k];
        root_q[k] <= root_n[k];
        vec_q[k]  <= (k == 0) ? vec_in : vec_q[k-1];
      end
    end
  end

  assign valid_out = vld[SQRT_STAGES-1];
  assign root      = root_q[SQRT_STAGES-1];
  assign vec_out   = vec_q[SQRT_STAGES-1];

endmodule

// ===== hdl/crg_div.sv =====
// ---------------------------------------------------------------------------
// crg_div
// Rounded quotient (mag*2^15 + len) / (2*len), restoring, one bit a stage.
// ---------------------------------------------------------------------------
module crg_div import crg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 valid_in,
  input  logic [30:0]          len,
  input  vec_pass_t            vec_in,
  output logic                 valid_out,
  output logic [QUOT_BITS-1:0] quot [3],
  output logic [2:0]           neg,
  output logic                 deg
);

  // prep stage
  logic [46:0] num_p [3];
  logic [31:0] den_p;
  logic [2:0]  neg_p;
  logic        deg_p, v_p;

  logic [46:0]          rem_q [QUOT_BITS][3];
  logic [QUOT_BITS-1:0] q_q   [QUOT_BITS][3];
  logic [31:0]          den_q [QUOT_BITS];
  logic [2:0]           neg_q [QUOT_BITS];
  logic                 deg_q [QUOT_BITS];
  logic [QUOT_BITS-1:0] vld;

  logic [46:0]          rem_c [QUOT_BITS][3];
  logic [QUOT_BITS-1:0] q_c   [QUOT_BITS][3];
  logic [31:0]          den_c [QUOT_BITS];
  logic [46:0]          dsh   [QUOT_BITS];
  logic [46:0]          rem_n [QUOT_BITS][3];
  logic [QUOT_BITS-1:0] q_n   [QUOT_BITS][3];

  // the quotient stays below 2^15 since no component exceeds len
  always_comb begin
    for (int k = 0; k < QUOT_BITS; k++) begin
      den_c[k] = (k == 0) ? den_p : den_q[k-1];
      dsh[k]   = 47'(den_c[k]) << (QUOT_BITS - 1 - k);
      for (int r = 0; r < 3; r++) begin
        rem_c[k][r] = (k == 0) ? num_p[r] : rem_q[k-1][r];
        q_c[k][r]   = (k == 0) ? '0 : q_q[k-1][r];
        if (rem_c[k][r] >= dsh[k]) begin
          rem_n[k][r] = rem_c[k][r] - dsh[k];
          q_n[k][r]   = q_c[k][r] | QUOT_BITS'(1 << (QUOT_BITS - 1 - k));
        end else begin
          rem_n[k][r] = rem_c[k][r];
          q_n[k][r]   = q_c[k][r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
      vld <= '0;
    end else if (adv) begin
      v_p <= valid_in;
      vld <= {vld[QUOT_BITS-2:0], v_p};
    end
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        num_p[r] <= (47'(vec_in.mag[r]) << 15) + 47'(len);
      end
      den_p <= {len, 1'b0};
      neg_p <= vec_in.neg;
      deg_p <= vec_in.deg;
      for (int k = 0; k < QUOT_BITS; k++) begin
        den_q[k] <= den_c[k];
        neg_q[k] <= (k == 0) ? neg_p : neg_q[k-1];
        deg_q[k] <= (k == 0) ? deg_p : deg_q[k-1];
        for (int r = 0; r < 3; r++) begin
          rem_q[k][r] <= rem_n[k][r];
          q_q[k][r]   <= q_n[k][r];
        end
      end
    end
  end

  assign valid_out = vld[QUOT_BITS-1];
  assign neg       = neg_q[QUOT_BITS-1];
  assign deg       = deg_q[QUOT_BITS-1];
  always_comb begin
    for (int r = 0; r < 3; r++) quot[r] = q_q[QUOT_BITS-1][r];
  end

endmodule

// ===== hdl/camera_ray_generator.sv =====
// ---------------------------------------------------------------------------
// camera_ray_generator
// Pinhole camera primary ray generation, one ray per clock unless the output stalls.
// ---------------------------------------------------------------------------
// Every pixel request gives one ray, passing through the view plane point,
// the matrix products and sums, the magnitudes, normalizing shift and sum of
// squares, the square root (one result bit a stage), the three restoring
// dividers (one quotient bit a stage) and the output register. A new request
// is taken every cycle; when the output is stalled with a ray waiting, the
// whole pipeline holds and in_stall rises. The user must write registers
// through the cfg port only while no request is in flight; the block itself
// does not enforce this. Writes to an index above 7 are dropped.
module camera_ray_generator import crg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t               cfg;
  logic               adv;
  logic               view_v, xf_v, norm_v, sq_v, div_v;
  logic signed [31:0] wx, wy;
  logic signed [53:0] d [3];
  logic [61:0]        sumsq;
  vec_pass_t          vec_n, vec_s;
  logic [30:0]        len;
  logic [QUOT_BITS-1:0] quot [3];
  logic [2:0]         neg;
  logic               deg;
  logic [15:0]        dir [3];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0]   <= 60'd65536;
      cfg.row[1]   <= 60'd68719476736;
      cfg.row[2]   <= 60'd72057594037927936;
      cfg.trans_xy <= '0;
      cfg.trans_z  <= '0;
      cfg.pitch    <= 32'd16777216;
      cfg.half_w   <= 32'd16777216;
      cfg.half_h   <= 32'd16777216;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INV_ROW_X:   cfg.row[0]   <= cfg_data[59:0];
        REG_INV_ROW_Y:   cfg.row[1]   <= cfg_data[59:0];
        REG_INV_ROW_Z:   cfg.row[2]   <= cfg_data[59:0];
        REG_TRANS_XY:    cfg.trans_xy <= cfg_data;
        REG_TRANS_Z:     cfg.trans_z  <= cfg_data[31:0];
        REG_PIXEL_PITCH: cfg.pitch    <= cfg_data[31:0];
        REG_HALF_W:      cfg.half_w   <= cfg_data[31:0];
        REG_HALF_H:      cfg.half_h   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  crg_view u_view (
    .clk, .rst, .adv,
    .valid_in  (in_valid),
    .req       (in_data),
    .cfg,
    .valid_out (view_v),
    .wx, .wy
  );

  crg_xform u_xform (
    .clk, .rst, .adv,
    .valid_in  (view_v),
    .wx, .wy,
    .cfg,
    .valid_out (xf_v),
    .d
  );

  crg_norm u_norm (
    .clk, .rst, .adv,
    .valid_in  (xf_v),
    .d,
    .valid_out (norm_v),
    .sumsq,
    .vec       (vec_n)
  );

  crg_isqrt u_isqrt (
    .clk, .rst, .adv,
    .valid_in  (norm_v),
    .n_in      (sumsq),
    .vec_in    (vec_n),
    .valid_out (sq_v),
    .root      (len),
    .vec_out   (vec_s)
  );

  crg_div u_div (
    .clk, .rst, .adv,
    .valid_in  (sq_v),
    .len,
    .vec_in    (vec_s),
    .valid_out (div_v),
    .quot,
    .neg,
    .deg
  );

  // zero direction forces the quotient to zero
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dir[r] = deg ? '0 : 16'(quot[r]);
      if (neg[r]) dir[r] = 16'(-dir[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_v;
    end
    if (adv) begin
      out_data.origin_x    <= $signed(cfg.trans_xy[31:0]);
      out_data.origin_y    <= $signed(cfg.trans_xy[63:32]);
      out_data.origin_z    <= $signed(cfg.trans_z);
      out_data.direction_x <= $signed(dir[0]);
      out_data.direction_y <= $signed(dir[1]);
      out_data.direction_z <= $signed(dir[2]);
      out_data.degenerate  <= deg;
    end
  end

endmodule

// ===== bench/camera_ray_generator_tb.sv =====
// ---------------------------------------------------------------------------
// camera_ray_generator_tb
// Drives pixel requests through the ray generator with random gaps and output
// stalls, predicts each ray in a bit-accurate fixed-point model and compares
// every field. Runs several register settings, extremes included.
// ---------------------------------------------------------------------------
module camera_ray_generator_tb;
  import crg_pkg::*;

  localparam int LATENCY   = 57;
  localparam int WDOG_MAX  = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_req_t    out_data;
  logic        cfg_write = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  camera_ray_generator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers
  logic [59:0] m_row [3];
  logic [63:0] m_trans_xy;
  logic [31:0] m_trans_z, m_pitch, m_half_w, m_half_h;

  in_req_t  pixel_q [$];
  out_req_t ray_q [$];
  int       errors = 0;
  int       wdog = 0;
  bit       stim_done = 0;
  bit       hold_off = 0;

  function automatic longint plane_coord(logic [31:0] half, logic [11:0] idx,
                                         logic [31:0] pitch);
    longint v;
    v = (longint'({32'd0, half}) <<< 7) -
        (longint'(2 * {52'd0, idx} + 64'd1) * longint'({32'd0, pitch}));
    v = (v + (64'sd1 <<< 14)) >>> 15;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > n) one >>= 2;
    while (one != 0) begin
      if (n >= res + one) begin
        n = n - (res + one);
        res = (res >> 1) + one;
      end else res >>= 1;
      one >>= 2;
    end
    return res;
  endfunction

  function automatic out_req_t predict_ray(in_req_t px);
    out_req_t r;
    longint w [3];
    longint d [3];
    longint unsigned mag [3];
    longint unsigned maxmag, sumsq, len, q;
    longint e;
    int s;
    maxmag = 0;
    sumsq = 0;
    w[0] = plane_coord(m_half_w, px.pixel_column & IDX_MASK, m_pitch);
    w[1] = plane_coord(m_half_h, px.pixel_row & IDX_MASK, m_pitch);
    w[2] = -65536;
    for (int i = 0; i < 3; i++) begin
      d[i] = 0;
      for (int j = 0; j < 3; j++) begin
        e = longint'($signed(m_row[i][20*j +: 20]));
        d[i] += e * w[j];
      end
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      if (mag[i] > maxmag) maxmag = mag[i];
    end
    s = 0;
    while ((maxmag >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= s;
      sumsq += mag[i] * mag[i];
    end
    len = int_sqrt(sumsq);
    r.origin_x = m_trans_xy[31:0];
    r.origin_y = m_trans_xy[63:32];
    r.origin_z = m_trans_z;
    r.degenerate = (maxmag == 0);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (maxmag != 0 && len != 0) q = (mag[i] * 64'd32768 + len) / (2 * len);
      if (d[i] < 0) q = -q;
      if (i == 0) r.direction_x = q[15:0];
      else if (i == 1) r.direction_y = q[15:0];
      else r.direction_z = q[15:0];
    end
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_INV_ROW_X:   m_row[0]   = val[59:0];
      REG_INV_ROW_Y:   m_row[1]   = val[59:0];
      REG_INV_ROW_Z:   m_row[2]   = val[59:0];
      REG_TRANS_XY:    m_trans_xy = val;
      REG_TRANS_Z:     m_trans_z  = val[31:0];
      REG_PIXEL_PITCH: m_pitch    = val[31:0];
      REG_HALF_W:      m_half_w   = val[31:0];
      default:         m_half_h   = val[31:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // out-of-range index: must be dropped
  task automatic write_bad_index();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= 4'd8 + 4'($urandom_range(0, 7));
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [19:0] rand_entry(int mode);
    case (mode)
      0: return 20'h10000 >> $urandom_range(0, 3);
      1: return 20'(-int'($urandom_range(0, 65536)));
      2: return 20'($urandom);
      default: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
    endcase
  endfunction

  task automatic wait_idle();
    while (pixel_q.size() != 0 || ray_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_pixel(logic [11:0] c, logic [11:0] r);
    in_req_t p;
    p.pixel_column = c;
    p.pixel_row = r;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic random_phase(int n, bit small_idx);
    for (int k = 0; k < n; k++)
      if (small_idx) queue_pixel(12'($urandom_range(0, 127)), 12'($urandom_range(0, 127)));
      else queue_pixel(12'($urandom), 12'($urandom));
  endtask

  // driver; the prediction is queued in the same step as the pop so the
  // idle check never sees both queues empty while a request is in flight
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        ray_q.insert(ray_q.size(), predict_ray(in_data));
        void'(pixel_q.pop_front());
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pixel_q[0];
      end else in_valid <= 1'b0;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_req_t exp_ray;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (ray_q.size() == 0) begin
          $error("ray with no request pending");
          errors++;
        end else begin
          exp_ray = ray_q.pop_front();
          if (out_data.origin_x !== exp_ray.origin_x) begin
            $error("origin_x exp %h got %h", exp_ray.origin_x, out_data.origin_x); errors++;
          end
          if (out_data.origin_y !== exp_ray.origin_y) begin
            $error("origin_y exp %h got %h", exp_ray.origin_y, out_data.origin_y); errors++;
          end
          if (out_data.origin_z !== exp_ray.origin_z) begin
            $error("origin_z exp %h got %h", exp_ray.origin_z, out_data.origin_z); errors++;
          end
          if (out_data.direction_x !== exp_ray.direction_x) begin
            $error("direction_x exp %h got %h", exp_ray.direction_x,
                   out_data.direction_x); errors++;
          end
          if (out_data.direction_y !== exp_ray.direction_y) begin
            $error("direction_y exp %h got %h", exp_ray.direction_y,
                   out_data.direction_y); errors++;
          end
          if (out_data.direction_z !== exp_ray.direction_z) begin
            $error("direction_z exp %h got %h", exp_ray.direction_z,
                   out_data.direction_z); errors++;
          end
          if (out_data.degenerate !== exp_ray.degenerate) begin
            $error("degenerate exp %b got %b", exp_ray.degenerate,
                   out_data.degenerate); errors++;
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
      end
      if (hold_off) out_stall <= 1'b1;
      else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (stim_done == 0 && pixel_q.size() > 100);
    @(posedge clk);
    hold_off = 1;
    repeat (150) @(posedge clk);
    hold_off = 0;
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else if (pixel_q.size() != 0 || ray_q.size() != 0) wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    m_row[0] = 60'd65536;
    m_row[1] = 60'd68719476736;
    m_row[2] = 60'd72057594037927936;
    m_trans_xy = '0;
    m_trans_z  = '0;
    m_pitch  = 32'd16777216;
    m_half_w = 32'd16777216;
    m_half_h = 32'd16777216;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, index extremes
    queue_pixel(0, 0);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_pixel(12'hFFF, 0);
    queue_pixel(0, 12'hFFF);
    queue_pixel(63, 64);
    queue_pixel(64, 63);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    wait_idle();

    // only row x has a nonzero entry, its z term; bad index ignored
    write_reg(REG_INV_ROW_X, 64'hFFFF_0000_0000_0000);
    write_reg(REG_INV_ROW_Y, '0);
    write_reg(REG_INV_ROW_Z, '0);
    write_bad_index();
    queue_pixel(0, 0);
    queue_pixel(12'hFFF, 12'h123);
    wait_idle();

    // extreme view plane, matrix and pitch
    write_reg(REG_INV_ROW_X, {20'h80000, 20'h80000, 20'h80000});
    write_reg(REG_INV_ROW_Y, {20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
    write_reg(REG_INV_ROW_Z, {20'h7FFFF, 20'h80000, 20'h00001});
    write_reg(REG_TRANS_XY, 64'hFFFF_FFFF_8000_0000);
    write_reg(REG_TRANS_Z, 64'h7FFF_FFFF);
    write_reg(REG_PIXEL_PITCH, 32'hFFFF_FFFF);
    write_reg(REG_HALF_W, 32'hFFFF_FFFF);
    write_reg(REG_HALF_H, 32'd0);
    queue_pixel(0, 0);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_pixel(12'h800, 1);
    queue_pixel(1, 12'h800);
    wait_idle();

    // identity matrix with the reset pitch and half extents
    write_reg(REG_INV_ROW_X, 64'd65536);
    write_reg(REG_INV_ROW_Y, 64'd65536 << 20);
    write_reg(REG_INV_ROW_Z, 64'd65536 << 40);
    write_reg(REG_PIXEL_PITCH, 32'd1 << 24);
    write_reg(REG_HALF_W, 32'd1 << 24);
    write_reg(REG_HALF_H, 32'd1 << 24);
    queue_pixel(31, 31);
    queue_pixel(32, 31);
    wait_idle();

    // random settings
    for (int ph = 0; ph < 10; ph++) begin
      int mode;
      mode = ph % 4;
      write_reg(REG_INV_ROW_X, {rand_entry(mode), rand_entry(mode), rand_entry(mode)});
      write_reg(REG_INV_ROW_Y, {rand_entry(mode), rand_entry(mode), rand_entry(mode)});
      write_reg(REG_INV_ROW_Z, {rand_entry(mode), rand_entry(mode), rand_entry(mode)});
      write_reg(REG_TRANS_XY, {$urandom, $urandom});
      write_reg(REG_TRANS_Z, {32'd0, $urandom});
      write_reg(REG_PIXEL_PITCH, ph == 9 ? 32'hFFFF_FFFF :
                                 $urandom_range(0, 1) ? $urandom : $urandom >> 8);
      write_reg(REG_HALF_W, ph == 8 ? 32'd0 : $urandom);
      write_reg(REG_HALF_H, ph == 9 ? 32'hFFFF_FFFF : $urandom);
      if (ph == 2) write_bad_index();
      random_phase(140, ph % 2 == 0);
      wait_idle();
    end
    stim_done = 1;
    wait_idle();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && ray_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
